>>> sv/sdrc_pkg.sv
// sdrc_pkg: shared constants for the stick deadzone repeat cursor block
// item codes, register indexes, table sizes, map defaults, payload widths and reset values of the registers
// no dependencies
package sdrc_pkg;

  // table size, fixed by the widths of active_index and entry_count
  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  // map defaults
  localparam int unsigned GRID_W_DEF = 32;
  localparam int unsigned GRID_H_DEF = 32;
  localparam int unsigned CELL_DEF   = 8;

  // item opcodes
  localparam logic [2:0] OP_KEY   = 3'd0;
  localparam logic [2:0] OP_NEXT  = 3'd1;
  localparam logic [2:0] OP_POLL  = 3'd2;
  localparam logic [2:0] OP_ADD   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // key codes
  localparam logic [2:0] KEY_UP    = 3'd0;
  localparam logic [2:0] KEY_DOWN  = 3'd1;
  localparam logic [2:0] KEY_LEFT  = 3'd2;
  localparam logic [2:0] KEY_RIGHT = 3'd3;
  localparam logic [2:0] KEY_NEXT  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE       = 2'd2;
  localparam logic [1:0] REG_PAD_PRESENT     = 2'd3;

  // register reset values
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd200;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [14:0] DEAD_ZONE_RST       = 15'd8000;
  localparam logic        PAD_PRESENT_RST     = 1'b1;

  // payload widths
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 32;

  // highest pixel position on an axis: tile * (grid - 1), capped to 0..255
  function automatic int limit_of(input int grid, input int tile);
    int m;
    m = grid * tile - tile;
    if (m > 255) m = 255;
    if (m < 0) m = 0;
    return m;
  endfunction

endpackage

>>> sv/stick_deadzone_repeat_cursor.sv
// stick_deadzone_repeat_cursor: position table with stick/dpad/key stepping and repeat timing
// depends on sdrc_pkg
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser opcode, tdata item fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata result fields
//  cfg      | in  | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while m_axis is not stalled: every item is a table read, a one-tile add and clamp and a
// 32-bit elapsed-time compare, all combinational in front of the result register.
// results appear in the cycle after the item is taken; the input is taken while the
// result register is empty or being drained, so a stall on m_axis holds s_axis.
// reset clears count, active entry, repeat state and result valid and loads the register reset values;
// the position table itself is not cleared.
module stick_deadzone_repeat_cursor
  import sdrc_pkg::*;
#(
  parameter int unsigned GRID_W = GRID_W_DEF,
  parameter int unsigned GRID_H = GRID_H_DEF,
  parameter int unsigned CELL   = CELL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // key_code[2:0], stick_x[18:3], stick_y[34:19], pad_up[35], pad_down[36],
  // pad_left[37], pad_right[38], now_ms[70:39], load_x[78:71], load_y[86:79], zero[87]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // active_index[3:0], pos_x_out[11:4], pos_y_out[19:12], entry_count[24:20],
  // moved[25], rejected[26], zero[31:27]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i
);

  localparam logic signed [9:0] LIM_X  = 10'(limit_of(int'(GRID_W), int'(CELL)));
  localparam logic signed [9:0] LIM_Y  = 10'(limit_of(int'(GRID_H), int'(CELL)));
  localparam logic signed [9:0] STEP_V = 10'(CELL);

  // configuration registers
  logic [15:0] repeat_delay_q, repeat_interval_q;
  logic [14:0] dead_zone_q;
  logic        pad_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_delay_q    <= REPEAT_DELAY_RST;
      repeat_interval_q <= REPEAT_INTERVAL_RST;
      dead_zone_q       <= DEAD_ZONE_RST;
      pad_present_q     <= PAD_PRESENT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REPEAT_DELAY:    repeat_delay_q    <= cfg_wdata_i;
        REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_wdata_i;
        REG_DEAD_ZONE:       dead_zone_q       <= cfg_wdata_i[14:0];
        REG_PAD_PRESENT:     pad_present_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // item fields
  logic [2:0]         opcode, key_code;
  logic signed [15:0] stick_x, stick_y;
  logic               pad_up, pad_down, pad_left, pad_right;
  logic [31:0]        now_ms;
  logic [7:0]         load_x, load_y;

  assign opcode    = s_axis_tuser[2:0];
  assign key_code  = s_axis_tdata[2:0];
  assign stick_x   = s_axis_tdata[18:3];
  assign stick_y   = s_axis_tdata[34:19];
  assign pad_up    = s_axis_tdata[35];
  assign pad_down  = s_axis_tdata[36];
  assign pad_left  = s_axis_tdata[37];
  assign pad_right = s_axis_tdata[38];
  assign now_ms    = s_axis_tdata[70:39];
  assign load_x    = s_axis_tdata[78:71];
  assign load_y    = s_axis_tdata[86:79];

  // state
  logic [7:0]       entry_x_q [MAX_ENTRIES];
  logic [7:0]       entry_y_q [MAX_ENTRIES];
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] active_q, active_d;
  logic             holding_q, holding_d;
  logic [31:0]      last_move_q, last_move_d;

  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next entry in round-robin order
  logic [IDX_W-1:0] next_sel;
  logic [CNT_W-1:0] active_inc;
  assign active_inc = CNT_W'(active_q) + CNT_W'(1);
  assign next_sel   = (active_inc >= count_q) ? '0 : active_inc[IDX_W-1:0];

  logic has_active;
  assign has_active = (count_q != '0) && (CNT_W'(active_q) < count_q);

  // single table read port
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_x, rd_y;
  assign rd_addr = (opcode == OP_NEXT) ? next_sel : active_q;
  assign rd_x    = entry_x_q[rd_addr];
  assign rd_y    = entry_y_q[rd_addr];

  // stick against the deadzone, dpad overrides in order up, down, left, right
  logic signed [16:0] sx_w, sy_w, dz_pos, dz_neg;
  logic st_l, st_r, st_u, st_d;
  logic pl, pr, pu, pd, poll_any;

  assign sx_w   = {stick_x[15], stick_x};
  assign sy_w   = {stick_y[15], stick_y};
  assign dz_pos = $signed({2'b00, dead_zone_q});
  assign dz_neg = -dz_pos;
  assign st_r   = sx_w > dz_pos;
  assign st_l   = sx_w < dz_neg;
  assign st_d   = sy_w > dz_pos;
  assign st_u   = sy_w < dz_neg;

  always_comb begin
    pu = st_u;
    pd = st_d;
    pl = st_l;
    pr = st_r;
    if (pad_up) begin
      {pu, pd, pl, pr} = 4'b1000;
    end else if (pad_down) begin
      {pu, pd, pl, pr} = 4'b0100;
    end else if (pad_left) begin
      {pu, pd, pl, pr} = 4'b0010;
    end else if (pad_right) begin
      {pu, pd, pl, pr} = 4'b0001;
    end
  end
  assign poll_any = pu || pd || pl || pr;

  // repeat timing, wraps modulo 2^32
  logic [31:0] elapsed, repeat_time;
  logic        repeat_due, poll_step;
  assign elapsed     = now_ms - last_move_q;
  assign repeat_due  = elapsed > {16'd0, repeat_delay_q};
  assign repeat_time = now_ms - {16'd0, repeat_delay_q} + {16'd0, repeat_interval_q};
  assign poll_step   = poll_any && (!holding_q || repeat_due);

  // key directions
  logic ku, kd, kl, kr, key_any;
  always_comb begin
    {ku, kd, kl, kr} = 4'b0000;
    case (key_code)
      KEY_UP:    ku = 1'b1;
      KEY_DOWN:  kd = 1'b1;
      KEY_LEFT:  kl = 1'b1;
      KEY_RIGHT: kr = 1'b1;
      default: ;
    endcase
  end
  assign key_any = ku || kd || kl || kr;

  // one tile step then clamp to the map
  logic mu, md, ml, mr;
  logic signed [9:0] vx, vy;
  logic [7:0] cx, cy;

  always_comb begin
    if (opcode == OP_POLL) begin
      {mu, md, ml, mr} = poll_step ? {pu, pd, pl, pr} : 4'b0000;
    end else begin
      {mu, md, ml, mr} = {ku, kd, kl, kr};
    end
    vx = $signed({2'b00, rd_x}) + (mr ? STEP_V : 10'sd0) - (ml ? STEP_V : 10'sd0);
    vy = $signed({2'b00, rd_y}) + (md ? STEP_V : 10'sd0) - (mu ? STEP_V : 10'sd0);
    if (vx > LIM_X) begin
      vx = LIM_X;
    end
    if (vx < 10'sd0) begin
      vx = 10'sd0;
    end
    if (vy > LIM_Y) begin
      vy = LIM_Y;
    end
    if (vy < 10'sd0) begin
      vy = 10'sd0;
    end
    cx = vx[7:0];
    cy = vy[7:0];
  end

  // item decode
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_x, wr_y, px, py;
  logic             moved, rejected;

  always_comb begin
    count_d     = count_q;
    active_d    = active_q;
    holding_d   = holding_q;
    last_move_d = last_move_q;
    wr_en       = 1'b0;
    wr_addr     = active_q;
    wr_x        = cx;
    wr_y        = cy;
    px          = '0;
    py          = '0;
    moved       = 1'b0;
    rejected    = 1'b0;
    unique case (opcode)
      OP_KEY: begin
        if (has_active) begin
          wr_en = 1'b1;
          px    = cx;
          py    = cy;
          moved = key_any;
          if (key_code == KEY_NEXT) begin
            active_d = next_sel;
          end
        end
      end
      OP_NEXT: begin
        if (count_q != '0) begin
          active_d = next_sel;
          px       = rd_x;
          py       = rd_y;
        end
      end
      OP_POLL: begin
        if (has_active) begin
          px = rd_x;
          py = rd_y;
          if (pad_present_q) begin
            wr_en = 1'b1;
            px    = cx;
            py    = cy;
            moved = poll_step;
            if (!poll_any) begin
              holding_d = 1'b0;
            end else if (!holding_q) begin
              holding_d   = 1'b1;
              last_move_d = now_ms;
            end else if (repeat_due) begin
              last_move_d = repeat_time;
            end
          end
        end
      end
      OP_ADD: begin
        if (count_q < CNT_W'(MAX_ENTRIES)) begin
          wr_en   = 1'b1;
          wr_addr = count_q[IDX_W-1:0];
          wr_x    = load_x;
          wr_y    = load_y;
          px      = load_x;
          py      = load_y;
          count_d = count_q + CNT_W'(1);
        end else begin
          rejected = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d  = '0;
        active_d = '0;
      end
      default: ;
    endcase
    out_data_d = {5'd0, rejected, moved, count_d, py, px, active_d};
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      entry_x_q[wr_addr] <= wr_x;
      entry_y_q[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      active_q    <= '0;
      holding_q   <= 1'b0;
      last_move_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        active_q    <= active_d;
        holding_q   <= holding_d;
        last_move_q <= last_move_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/sdrc_checker.sv
// sdrc_checker: port-level checks for stick_deadzone_repeat_cursor, bound to the top level
// depends on sdrc_pkg
module sdrc_checker
  import sdrc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [IDX_W-1:0] act;
  logic [CNT_W-1:0] cnt;
  logic             moved, rejected;
  assign act      = m_axis_tdata[3:0];
  assign cnt      = m_axis_tdata[24:20];
  assign moved    = m_axis_tdata[25];
  assign rejected = m_axis_tdata[26];

  // a stalled result blocks new items
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // every taken item yields a result next cycle
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("taken item produced no result");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // active entry lies inside the table, or is zero when empty
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((cnt <= CNT_W'(MAX_ENTRIES)) &&
                       ((cnt == '0) ? (act == '0) : (CNT_W'(act) < cnt))))
    else $error("active index or count out of range");

  // a refused add only happens on a full table and moves nothing
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rejected) |-> ((cnt == CNT_W'(MAX_ENTRIES)) && !moved))
    else $error("reject without full table");

endmodule

bind stick_deadzone_repeat_cursor sdrc_checker u_sdrc_checker (.*);

>>> sim/tb_stick_deadzone_repeat_cursor.sv
// testbench for stick_deadzone_repeat_cursor: stream driver, result checker and
// an in-bench cursor predictor, run across several register settings
// depends on sdrc_pkg and the stick_deadzone_repeat_cursor rtl
`timescale 1ns / 100ps

module tb_stick_deadzone_repeat_cursor;
  import sdrc_pkg::*;

  // codes that the package leaves unnamed
  localparam logic [2:0] OP_RSVD_A  = 3'd5;
  localparam logic [2:0] OP_RSVD_B  = 3'd6;
  localparam logic [2:0] OP_RSVD_C  = 3'd7;
  localparam logic [2:0] KEY_OTHER  = 3'd5;
  localparam logic [2:0] KEY_RSVD_A = 3'd6;
  localparam logic [2:0] KEY_RSVD_B = 3'd7;

  localparam int STEP_PX   = CELL_DEF;
  localparam int SPAN_X    = (int'(GRID_W_DEF) - 1) * STEP_PX;
  localparam int SPAN_Y    = (int'(GRID_H_DEF) - 1) * STEP_PX;
  localparam int POS_MAX_X = SPAN_X > 255 ? 255 : (SPAN_X < 0 ? 0 : SPAN_X);
  localparam int POS_MAX_Y = SPAN_Y > 255 ? 255 : (SPAN_Y < 0 ? 0 : SPAN_Y);

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic [2:0]         opcode;
    logic [2:0]         key_code;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic               pad_up;
    logic               pad_down;
    logic               pad_left;
    logic               pad_right;
    logic [31:0]        now_ms;
    logic [7:0]         load_x;
    logic [7:0]         load_y;
  } cursor_item_t;

  typedef struct {
    logic [3:0] active_index;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [4:0] entry_count;
    logic       moved;
    logic       rejected;
  } cursor_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = REG_REPEAT_DELAY;
  logic [15:0]           cfg_wdata_i = '0;

  stick_deadzone_repeat_cursor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cursor_item_t   pending_items[$];
  cursor_result_t expected_results[$];

  // predicted cursor state
  logic [7:0]  tbl_x [MAX_ENTRIES];
  logic [7:0]  tbl_y [MAX_ENTRIES];
  int          tbl_count = 0;
  int          act_idx = 0;
  bit          holding = 1'b0;
  logic [31:0] last_step_ms = '0;
  logic [15:0] cfg_delay = REPEAT_DELAY_RST;
  logic [15:0] cfg_interval = REPEAT_INTERVAL_RST;
  logic [14:0] cfg_dz = DEAD_ZONE_RST;
  logic        cfg_pad = PAD_PRESENT_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int gen_count = 0;
  logic [31:0] gen_ms = '0;
  int n_items = 0, n_results = 0, n_moves = 0, n_rejects = 0, n_errors = 0;
  int quiet_cycles = 0;

  int phase_delay    [NUM_PHASES] = '{200, 0, 65535, 300, 50, 0, 65535, 1};
  int phase_interval [NUM_PHASES] = '{100, 0, 65535, 40, 300, 0, 0, 65535};
  int phase_dz       [NUM_PHASES] = '{8000, 0, 32767, 20000, 1000, 0, 0, 16000};
  int phase_pad      [NUM_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0};

  function automatic logic [7:0] clamp_axis(input int v, input int hi);
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return 8'(v);
  endfunction

  // one tile step of entry i; a zero step just pulls it back onto the map
  task automatic nudge_entry(input int i, input int dx, input int dy);
    tbl_x[i] = clamp_axis(int'(tbl_x[i]) + dx * STEP_PX, POS_MAX_X);
    tbl_y[i] = clamp_axis(int'(tbl_y[i]) + dy * STEP_PX, POS_MAX_Y);
  endtask

  task automatic predict_cursor(input cursor_item_t it, output cursor_result_t r);
    int a, dx, dy, sx, sy, dz, px, py;
    logic [31:0] elapsed;
    a = act_idx;
    dx = 0;
    dy = 0;
    px = 0;
    py = 0;
    r.moved = 1'b0;
    r.rejected = 1'b0;
    if (it.opcode == OP_KEY && tbl_count > 0 && a < tbl_count) begin
      case (it.key_code)
        KEY_UP:    dy = -1;
        KEY_DOWN:  dy = 1;
        KEY_LEFT:  dx = -1;
        KEY_RIGHT: dx = 1;
        default: ;
      endcase
      nudge_entry(a, dx, dy);
      r.moved = (dx != 0 || dy != 0);
      if (it.key_code == KEY_NEXT) act_idx = (a + 1) % tbl_count;
      px = tbl_x[a];
      py = tbl_y[a];
    end else if (it.opcode == OP_NEXT && tbl_count > 0) begin
      act_idx = (a + 1) % tbl_count;
      px = tbl_x[act_idx];
      py = tbl_y[act_idx];
    end else if (it.opcode == OP_POLL && tbl_count > 0 && a < tbl_count) begin
      if (cfg_pad) begin
        sx = it.stick_x;
        sy = it.stick_y;
        dz = cfg_dz;
        if (sx > dz) dx = 1;
        if (sx < -dz) dx = -1;
        if (sy > dz) dy = 1;
        if (sy < -dz) dy = -1;
        // dpad wins over the stick, up first
        if (it.pad_up) begin
          dx = 0;
          dy = -1;
        end else if (it.pad_down) begin
          dx = 0;
          dy = 1;
        end else if (it.pad_left) begin
          dx = -1;
          dy = 0;
        end else if (it.pad_right) begin
          dx = 1;
          dy = 0;
        end
        elapsed = it.now_ms - last_step_ms;
        if (dx != 0 || dy != 0) begin
          if (!holding) begin
            nudge_entry(a, dx, dy);
            r.moved = 1'b1;
            holding = 1'b1;
            last_step_ms = it.now_ms;
          end else if (elapsed > 32'(cfg_delay)) begin
            nudge_entry(a, dx, dy);
            r.moved = 1'b1;
            last_step_ms = it.now_ms - (32'(cfg_delay) - 32'(cfg_interval));
          end else begin
            nudge_entry(a, 0, 0);
          end
        end else begin
          holding = 1'b0;
          nudge_entry(a, 0, 0);
        end
      end
      px = tbl_x[a];
      py = tbl_y[a];
    end else if (it.opcode == OP_ADD) begin
      if (tbl_count < MAX_ENTRIES) begin
        tbl_x[tbl_count] = it.load_x;
        tbl_y[tbl_count] = it.load_y;
        px = it.load_x;
        py = it.load_y;
        tbl_count++;
      end else begin
        r.rejected = 1'b1;
      end
    end else if (it.opcode == OP_CLEAR) begin
      tbl_count = 0;
      act_idx = 0;
    end
    r.active_index = 4'(act_idx);
    r.pos_x = 8'(px);
    r.pos_y = 8'(py);
    r.entry_count = 5'(tbl_count);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // driver: holds an offered item until taken, predicts it on acceptance
  always @(posedge clk_i) begin : driver_proc
    cursor_item_t   nxt;
    cursor_result_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        nxt = pending_items.pop_front();
        predict_cursor(nxt, res);
        expected_results.insert(expected_results.size(), res);
        n_items++;
        n_moves += res.moved;
        n_rejects += res.rejected;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // offered item stays put
      end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, nxt.load_y, nxt.load_x, nxt.now_ms, nxt.pad_right,
                          nxt.pad_left, nxt.pad_down, nxt.pad_up, nxt.stick_y,
                          nxt.stick_x, nxt.key_code};
        s_axis_tuser  <= nxt.opcode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    cursor_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.active_index = m_axis_tdata[3:0];
        got.pos_x        = m_axis_tdata[11:4];
        got.pos_y        = m_axis_tdata[19:12];
        got.entry_count  = m_axis_tdata[24:20];
        got.moved        = m_axis_tdata[25];
        got.rejected     = m_axis_tdata[26];
        n_results++;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: 0x%08h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.active_index != want.active_index)
            flag_mismatch($sformatf("active_index got %0d want %0d",
                                    got.active_index, want.active_index));
          if (got.pos_x != want.pos_x)
            flag_mismatch($sformatf("pos_x_out got %0d want %0d", got.pos_x, want.pos_x));
          if (got.pos_y != want.pos_y)
            flag_mismatch($sformatf("pos_y_out got %0d want %0d", got.pos_y, want.pos_y));
          if (got.entry_count != want.entry_count)
            flag_mismatch($sformatf("entry_count got %0d want %0d",
                                    got.entry_count, want.entry_count));
          if (got.moved != want.moved)
            flag_mismatch($sformatf("moved got %0d want %0d", got.moved, want.moved));
          if (got.rejected != want.rejected)
            flag_mismatch($sformatf("rejected got %0d want %0d", got.rejected, want.rejected));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic cursor_item_t rand_item(input logic [2:0] op);
    cursor_item_t it;
    it.opcode    = op;
    it.key_code  = 3'($urandom_range(0, 7));
    it.stick_x   = 16'($urandom);
    it.stick_y   = 16'($urandom);
    it.pad_up    = 1'($urandom);
    it.pad_down  = 1'($urandom);
    it.pad_left  = 1'($urandom);
    it.pad_right = 1'($urandom);
    it.now_ms    = $urandom;
    it.load_x    = 8'($urandom);
    it.load_y    = 8'($urandom);
    return it;
  endfunction

  // pads: bit 0 up, 1 down, 2 left, 3 right
  function automatic cursor_item_t poll_item(input int sx, input int sy,
                                             input logic [3:0] pads, input logic [31:0] ms);
    cursor_item_t it;
    it = rand_item(OP_POLL);
    it.stick_x   = 16'(sx);
    it.stick_y   = 16'(sy);
    it.pad_up    = pads[0];
    it.pad_down  = pads[1];
    it.pad_left  = pads[2];
    it.pad_right = pads[3];
    it.now_ms    = ms;
    return it;
  endfunction

  function automatic int stick_quiet();
    return int'($urandom_range(0, 2 * int'(cfg_dz))) - int'(cfg_dz);
  endfunction

  // a deflection beyond the deadzone; a full positive deadzone leaves only -32768
  function automatic int stick_push(input bit neg);
    if (!neg && cfg_dz < 15'd32767)
      return int'(cfg_dz) + 1 + int'($urandom_range(0, 32766 - int'(cfg_dz)));
    return -(int'(cfg_dz) + 1) - int'($urandom_range(0, 32767 - int'(cfg_dz)));
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 32'(cfg_delay) + 1);
      1:       return 32'(cfg_delay) + $urandom_range(0, 2) - 1;
      2:       return $urandom_range(0, 32'(cfg_interval) + 1);
      default: return $urandom_range(0, 32'(cfg_delay) + 32'(cfg_interval) + 2);
    endcase
  endfunction

  // the table fill level depends only on adds and clears, so track it here
  task automatic queue_item(input cursor_item_t it);
    pending_items.insert(pending_items.size(), it);
    if (it.opcode == OP_ADD && gen_count < MAX_ENTRIES) gen_count++;
    else if (it.opcode == OP_CLEAR) gen_count = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_REPEAT_DELAY:    cfg_delay = val;
      REG_REPEAT_INTERVAL: cfg_interval = val;
      REG_DEAD_ZONE:       cfg_dz = val[14:0];
      REG_PAD_PRESENT:     cfg_pad = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic gen_random(input int target);
    int made, r, len, dir, j;
    bit use_pad;
    int sx, sy;
    logic [3:0] pads;
    made = 0;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if ((gen_count == 0 && r < 50) || r < 18) begin
        len = $urandom_range(1, 6);
        repeat (len) queue_item(rand_item(OP_ADD));
        made += len;
      end else if (r < 21) begin
        queue_item(rand_item(OP_CLEAR));
        made++;
      end else if (r < 40) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_item(rand_item(OP_KEY));
        made += len;
      end else if (r < 47) begin
        queue_item(rand_item(OP_NEXT));
        made++;
      end else if (r < 85) begin
        // held direction: a run of polls, then usually a release
        if ($urandom_range(0, 9) == 0) gen_ms = $urandom;
        dir = $urandom_range(0, 3);
        len = $urandom_range(2, 8);
        use_pad = 1'($urandom);
        repeat (len) begin
          gen_ms += pick_step();
          pads = '0;
          if (use_pad) begin
            sx = $urandom_range(0, 65535) - 32768;
            sy = $urandom_range(0, 65535) - 32768;
            pads[dir] = 1'b1;
            for (j = dir + 1; j < 4; j++) pads[j] = 1'($urandom);
          end else begin
            sx = stick_quiet();
            sy = stick_quiet();
            if (dir < 2) begin
              sy = stick_push(dir == 0);
              if ($urandom_range(0, 9) < 3) sx = stick_push(1'($urandom));
            end else begin
              sx = stick_push(dir == 2);
              if ($urandom_range(0, 9) < 3) sy = stick_push(1'($urandom));
            end
          end
          queue_item(poll_item(sx, sy, pads, gen_ms));
        end
        made += len;
        if ($urandom_range(0, 3) != 0) begin
          gen_ms += pick_step();
          queue_item(poll_item(stick_quiet(), stick_quiet(), '0, gen_ms));
          made++;
        end
      end else begin
        queue_item(rand_item(3'($urandom_range(0, 7))));
        made++;
      end
    end
  endtask

  initial begin : stimulus_proc
    cursor_item_t it;
    logic [2:0] key_order [8];
    int ph, k;
    key_order = '{KEY_OTHER, KEY_DOWN, KEY_RIGHT, KEY_UP, KEY_LEFT,
                  KEY_RSVD_A, KEY_RSVD_B, KEY_NEXT};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, unused opcodes
    it = rand_item(OP_KEY);
    it.key_code = KEY_UP;
    queue_item(it);
    queue_item(rand_item(OP_NEXT));
    queue_item(rand_item(OP_POLL));
    queue_item(rand_item(OP_RSVD_A));
    queue_item(rand_item(OP_RSVD_B));
    queue_item(rand_item(OP_RSVD_C));
    // off-map corner first so the keys below hit the clamp
    it = rand_item(OP_ADD);
    it.load_x = 8'hFF;
    it.load_y = 8'hFF;
    queue_item(it);
    it.load_x = 8'h00;
    it.load_y = 8'h00;
    queue_item(it);
    for (k = 0; k < 8; k++) begin
      it = rand_item(OP_KEY);
      it.key_code = key_order[k];
      queue_item(it);
    end
    queue_item(rand_item(OP_NEXT));
    // all pads at once, hold inside the delay, repeat, release at the deadzone edge
    queue_item(poll_item(0, 0, 4'b1111, 32'd5));
    queue_item(poll_item(32767, 0, 4'b0000, 32'd100));
    queue_item(poll_item(0, -32768, 4'b0000, 32'd300));
    queue_item(poll_item(8000, -8000, 4'b0000, 32'd301));
    // fresh press just before the timestamp wraps, repeat just after it
    queue_item(poll_item(-32768, 0, 4'b0000, 32'hFFFF_FFF0));
    queue_item(poll_item(8001, 0, 4'b1000, 32'h0000_0100));
    queue_item(rand_item(OP_CLEAR));
    it = rand_item(OP_ADD);
    it.load_x = 8'h5A;
    it.load_y = 8'hA5;
    queue_item(it);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (ph == 5) begin
        phase_delay[ph]    = $urandom_range(0, 1000);
        phase_interval[ph] = $urandom_range(0, 500);
        phase_dz[ph]       = $urandom_range(0, 32767);
      end
      write_reg(REG_REPEAT_DELAY, 16'(phase_delay[ph]));
      write_reg(REG_REPEAT_INTERVAL, 16'(phase_interval[ph]));
      write_reg(REG_DEAD_ZONE, 16'(phase_dz[ph]));
      write_reg(REG_PAD_PRESENT, 16'(phase_pad[ph]));
      gen_random(PHASE_ITEMS);
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d items over %0d register settings: %0d tile steps, %0d adds refused",
             n_items, NUM_PHASES + 1, n_moves, n_rejects);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
